### design/tma_pkg.sv
// ----------------------------------------------------------------------------
// tma_pkg: shared types and constants for the tick to millisecond accumulator
// Widths, fixed constants and the command and status structs of the serial divider.
// ----------------------------------------------------------------------------
package tma_pkg;

  localparam int TICK_W  = 32;          // tick reading and millisecond total
  localparam int RATE_W  = 23;          // tick rate, remainder, divisor
  localparam int NUM_W   = TICK_W + 1;  // dividend of the wide divisions
  localparam int CARRY_W = 10;          // thousandths of a tick, and gain
  localparam int CNT_W   = 6;           // holds a step count up to NUM_W

  localparam logic [RATE_W-1:0]  DEFAULT_RATE_HZ = 23'd709379;
  localparam logic [CARRY_W-1:0] MS_PER_SEC      = 10'd1000;

  // Step counts of the two kinds of division pass
  localparam logic [CNT_W-1:0] STEPS_WIDE = CNT_W'(NUM_W);
  localparam logic [CNT_W-1:0] STEPS_FINE = CNT_W'(CARRY_W);

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] steps;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic qbit;
    logic last;
  } div_stat_t;

endpackage

### design/tma_serdiv.sv
// ----------------------------------------------------------------------------
// tma_serdiv: bit-serial restoring divider
// One quotient bit per cycle; the partial remainder must start below the divisor.
// ----------------------------------------------------------------------------
module tma_serdiv (
  input  logic                        clk,
  input  logic                        rst,
  input  tma_pkg::div_cmd_t           cmd,
  input  logic [tma_pkg::NUM_W-1:0]   num,
  input  logic [tma_pkg::RATE_W-1:0]  p_init,
  input  logic [tma_pkg::RATE_W-1:0]  divisor,
  output tma_pkg::div_stat_t          stat,
  output logic [tma_pkg::RATE_W-1:0]  rem,
  output logic [tma_pkg::RATE_W-1:0]  quo
);
  import tma_pkg::*;

  logic [RATE_W-1:0] p;
  logic [RATE_W-1:0] dvs;
  logic [RATE_W-1:0] quo_sr;
  logic [NUM_W-1:0]  nsr;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [RATE_W:0]   trial;
  logic [RATE_W:0]   diff;
  logic              qbit;

  // Shift the next dividend bit into the partial remainder and try a subtract
  assign trial = {p, nsr[NUM_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign qbit  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      cnt  <= cmd.steps;
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      p      <= p_init;
      nsr    <= num;
      dvs    <= divisor;
      quo_sr <= '0;
    end else if (busy) begin
      p      <= qbit ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      nsr    <= {nsr[NUM_W-2:0], 1'b0};
      quo_sr <= {quo_sr[RATE_W-2:0], qbit};
    end
  end

  assign stat.busy = busy;
  assign stat.qbit = qbit;
  assign stat.last = busy && (cnt == CNT_W'(1));
  assign rem       = p;
  assign quo       = quo_sr;

endmodule

### design/tick_to_millisecond_accumulator_unit.sv
// ----------------------------------------------------------------------------
// tick_to_millisecond_accumulator_unit: drift-free millisecond total
// Converts free-running tick readings into a wrapping millisecond count.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | transfer when
//  --------+----------------------------------+-------------------------------
//  input   | in_valid, in_stall, tick_reading | in_valid && !in_stall
//  output  | out_valid, out_stall, millis     | out_valid && !out_stall
//  config  | cfg_we, cfg_wdata (tick rate)    | cfg_we
//
//  Each reading, from its transfer to the next possible input transfer, runs
//  three passes through one shared bit-serial divider (33, 10 and 33 steps)
//  plus the LOAD, FIN and DONE sequencing states; the divider makes one bit
//  per cycle. A priming reading skips the passes and goes straight to DONE.
//  Reset (synchronous) clears the totals, unprimes the block and loads the
//  rate register with 709379. A finished result waits in the output register
//  under out_stall while the next reading is already accepted and worked on.
//
//  Per reading, with hz the effective rate and tr the stored remainder:
//    pass A: (delta + tr) / hz      -> whole seconds, added as 1000 ms each
//    pass B: rem * 1000 / hz        -> gain in milliseconds (below 1000)
//    pass C: (gain*hz + carry)/1000 -> ticks used, new thousandths carry
//  Folding tr into the first division gives the same seconds and remainder
//  as dividing delta and the remainder sum separately.
// ----------------------------------------------------------------------------
module tick_to_millisecond_accumulator_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tma_pkg::TICK_W-1:0]  tick_reading,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tma_pkg::TICK_W-1:0]  millis,
  input  logic                        cfg_we,
  input  logic [tma_pkg::RATE_W-1:0]  cfg_wdata
);
  import tma_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOADA = 9'b000000010,
    S_DIVA  = 9'b000000100,
    S_LOADB = 9'b000001000,
    S_DIVB  = 9'b000010000,
    S_LOADC = 9'b000100000,
    S_DIVC  = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state, state_next;

  // Configuration and accumulator state
  logic [RATE_W-1:0]  tick_rate_hz;
  logic               primed;
  logic [TICK_W-1:0]  last_tick;
  logic [TICK_W-1:0]  millis_total;
  logic [RATE_W-1:0]  tick_remainder;
  logic [CARRY_W-1:0] carry;

  // Per-reading working registers
  logic [TICK_W-1:0]  reading_q;
  logic [RATE_W-1:0]  hz_q;
  logic [RATE_W-1:0]  rem2;
  logic [CARRY_W-1:0] gain_r;
  logic [TICK_W-1:0]  acc_ms;

  logic               in_xfer;
  logic               out_free;
  logic [RATE_W-1:0]  hz_eff;
  logic [NUM_W-1:0]   num_a;
  logic [NUM_W-1:0]   prod_b;
  logic [NUM_W-1:0]   num_c;
  logic [RATE_W-1:0]  tr_next;

  // Divider interface
  div_cmd_t           div_cmd;
  div_stat_t          div_stat;
  logic [NUM_W-1:0]   div_num;
  logic [RATE_W-1:0]  div_pinit;
  logic [RATE_W-1:0]  div_dvs;
  logic [RATE_W-1:0]  div_rem;
  logic [RATE_W-1:0]  div_quo;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign hz_eff   = (tick_rate_hz == '0) ? DEFAULT_RATE_HZ : tick_rate_hz;

  // Wrap-safe delta plus the stored remainder
  assign num_a  = {1'b0, reading_q - last_tick} + NUM_W'(tick_remainder);
  // Remainder scaled to thousandths; its top bits already sit below hz
  assign prod_b = NUM_W'(div_rem) * NUM_W'(MS_PER_SEC);
  // Ticks consumed by the gain, in thousandths, plus the old carry
  assign num_c  = NUM_W'(div_quo[CARRY_W-1:0]) * NUM_W'(hz_q) + NUM_W'(carry);
  // Take out the used ticks, saturating at zero
  assign tr_next = (div_quo > rem2) ? '0 : (rem2 - div_quo);

  tma_serdiv u_div (
    .clk     (clk),
    .rst     (rst),
    .cmd     (div_cmd),
    .num     (div_num),
    .p_init  (div_pinit),
    .divisor (div_dvs),
    .stat    (div_stat),
    .rem     (div_rem),
    .quo     (div_quo)
  );

  // Sequencer: next state and divider launch
  always_comb begin
    state_next    = state;
    div_cmd.start = 1'b0;
    div_cmd.steps = STEPS_WIDE;
    div_num       = num_a;
    div_pinit     = '0;
    div_dvs       = hz_q;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = primed ? S_LOADA : S_DONE;
        end
      end
      S_LOADA: begin
        div_cmd.start = 1'b1;
        state_next    = S_DIVA;
      end
      S_DIVA: begin
        if (div_stat.last) begin
          state_next = S_LOADB;
        end
      end
      S_LOADB: begin
        div_cmd.start = 1'b1;
        div_cmd.steps = STEPS_FINE;
        div_num       = {prod_b[CARRY_W-1:0], RATE_W'(0)};
        div_pinit     = prod_b[NUM_W-1:CARRY_W];
        state_next    = S_DIVB;
      end
      S_DIVB: begin
        if (div_stat.last) begin
          state_next = S_LOADC;
        end
      end
      S_LOADC: begin
        div_cmd.start = 1'b1;
        div_num       = num_c;
        div_dvs       = RATE_W'(MS_PER_SEC);
        state_next    = S_DIVC;
      end
      S_DIVC: begin
        if (div_stat.last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control and accumulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      tick_rate_hz   <= DEFAULT_RATE_HZ;
      primed         <= 1'b0;
      last_tick      <= '0;
      millis_total   <= '0;
      tick_remainder <= '0;
      carry          <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        tick_rate_hz <= cfg_wdata;
      end
      // Priming reading: store it, clear the totals, report zero
      if (in_xfer && !primed) begin
        primed         <= 1'b1;
        last_tick      <= tick_reading;
        millis_total   <= '0;
        tick_remainder <= '0;
        carry          <= '0;
      end
      if (state == S_FIN) begin
        last_tick      <= reading_q;
        millis_total   <= millis_total + acc_ms + TICK_W'(gain_r);
        tick_remainder <= tr_next;
        carry          <= div_rem[CARRY_W-1:0];
      end
      // Drop a result once taken, load a new one when the slot is free
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      reading_q <= tick_reading;
      hz_q      <= hz_eff;
    end
    if (state == S_LOADA) begin
      acc_ms <= '0;
    end else if (state == S_DIVA && div_stat.busy) begin
      // Build quotient * 1000 one bit at a time, modulo 2^32
      acc_ms <= {acc_ms[TICK_W-2:0], 1'b0} +
                (div_stat.qbit ? TICK_W'(MS_PER_SEC) : TICK_W'(0));
    end
    if (state == S_LOADB) begin
      rem2 <= div_rem;
    end
    if (state == S_LOADC) begin
      gain_r <= div_quo[CARRY_W-1:0];
    end
    if (state == S_DONE && out_free) begin
      millis <= millis_total;
    end
  end

  // The coarse pass leaves a remainder below the rate
  a_rem_below_rate: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVA && div_stat.last) |=> (div_rem < hz_q))
    else $error("remainder not below rate after coarse division");

  // The thousandths carry stays below one tick
  a_carry_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> (carry < MS_PER_SEC))
    else $error("thousandths carry out of range");

  // A priming reading skips every division pass
  a_prime_direct: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !primed) |=> (state == S_DONE))
    else $error("priming reading entered the divide sequence");

  // The divider is never left running while the block waits for input
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_stat.busy)
    else $error("divider busy while idle");

endmodule

### sim/tick_to_millisecond_accumulator_unit_tb.sv
// ----------------------------------------------------------------------------
// tick_to_millisecond_accumulator_unit_tb: self-checking bench for the unit
// Feeds tick readings through the valid/stall input channel under several
// tick rates, predicts every millisecond total and checks each output
// transfer in order. Both channels idle at random, and the output is held
// off once for a long stretch so the unit backs up into its input.
// ----------------------------------------------------------------------------
module tick_to_millisecond_accumulator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tma_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 2000;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_ITEMS = 158;
  localparam int unsigned MAX_PRINTED = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [TICK_W-1:0] tick_reading = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [TICK_W-1:0] millis;
  logic              cfg_we = 1'b0;
  logic [RATE_W-1:0] cfg_wdata = '0;

  tick_to_millisecond_accumulator_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .tick_reading(tick_reading),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .millis      (millis),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  // Readings waiting for the driver, and totals waiting for the unit to emit
  logic [TICK_W-1:0] pending_readings[$];
  logic [TICK_W-1:0] expected_millis[$];

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_on = 1'b1;      // random gaps and stalls on both channels
  bit          hold_request = 1'b0; // ask for the long output hold-off
  bit          hold_seen = 1'b0;
  logic        hold_off = 1'b0;
  int unsigned hold_left = 0;

  // Predictor copy of the unit state and its rate register
  bit                 acc_primed = 1'b0;
  logic [TICK_W-1:0]  acc_last = '0;
  logic [TICK_W-1:0]  acc_total = '0;
  logic [RATE_W-1:0]  acc_rem = '0;
  logic [CARRY_W-1:0] acc_carry = '0;
  logic [RATE_W-1:0]  acc_rate = DEFAULT_RATE_HZ;

  // Stimulus side: last reading queued and the rate in force
  logic [TICK_W-1:0] gen_last = '0;
  logic [RATE_W-1:0] gen_rate = DEFAULT_RATE_HZ;

  initial begin
    forever #5 clk = ~clk;
  end

  // Advance the predicted state by one reading and return the new total.
  function automatic logic [TICK_W-1:0] accumulate_millis(input logic [TICK_W-1:0] reading);
    logic [31:0] hz;
    logic [31:0] delta;
    logic [31:0] gain;
    logic [31:0] used;
    logic [63:0] rem;
    logic [63:0] num;
    if (!acc_primed) begin
      // Priming reading: remember it and start the total from zero
      acc_primed = 1'b1;
      acc_last = reading;
      acc_total = '0;
      acc_rem = '0;
      acc_carry = '0;
      return '0;
    end
    hz = (acc_rate != '0) ? 32'(acc_rate) : 32'(DEFAULT_RATE_HZ);
    delta = reading - acc_last;
    acc_last = reading;
    acc_total = acc_total + (delta / hz) * 32'(MS_PER_SEC);
    // Fold the leftover ticks in; after a rate drop this can hold whole seconds
    rem = 64'(acc_rem) + 64'(delta % hz);
    acc_total = acc_total + 32'(rem / 64'(hz)) * 32'(MS_PER_SEC);
    rem = rem % 64'(hz);
    gain = 32'((rem * 64'(MS_PER_SEC)) / 64'(hz));
    acc_total = acc_total + gain;
    // Ticks spent on those milliseconds, kept to a thousandth of a tick
    num = 64'(gain) * 64'(hz) + 64'(acc_carry);
    used = 32'(num / 64'(MS_PER_SEC));
    rem = (64'(used) > rem) ? 64'd0 : rem - 64'(used);
    acc_rem = rem[RATE_W-1:0];
    acc_carry = CARRY_W'(num % 64'(MS_PER_SEC));
    return acc_total;
  endfunction

  task automatic report_mismatch(input string what, input logic [TICK_W-1:0] got,
                                 input logic [TICK_W-1:0] want);
    if (fail_count < MAX_PRINTED)
      $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
    fail_count++;
  endtask

  task automatic queue_reading(input logic [TICK_W-1:0] reading);
    pending_readings.push_back(reading);
    gen_last = reading;
  endtask

  // Pick a tick gap that lands on the interesting spots for rate hz.
  function automatic logic [TICK_W-1:0] draw_delta(input logic [31:0] hz);
    logic [31:0] k;
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 15);
      1, 2: return $urandom_range(0, hz - 1);
      3: begin
        k = $urandom_range(1, 4);
        return hz * k + $urandom_range(0, 6) - 3;
      end
      4: return $urandom;
      5: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: return $urandom_range(0, hz * 3);
    endcase
  endfunction

  // Write the rate register; only called while the unit is idle.
  task automatic write_rate(input logic [RATE_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    acc_rate = value;
    gen_rate = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued reading has gone in and every total has come out.
  task automatic wait_for_drain();
    @(negedge clk);
    while (pending_readings.size() != 0 || in_valid || expected_millis.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Driver: offer queued readings, with a random gap before each one.
  int unsigned gap_left = 0;
  always @(posedge clk) begin
    int unsigned w;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (in_valid && !in_stall) begin
      // Transfer at this edge: hold valid high only for a back-to-back item
      w = idle_on ? $urandom_range(0, 10) : 0;
      if (w == 0 && pending_readings.size() != 0) begin
        tick_reading <= pending_readings.pop_front();
      end else begin
        in_valid <= 1'b0;
        gap_left <= (w == 0) ? 0 : w - 1;
      end
    end else if (!in_valid) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_readings.size() != 0) begin
        tick_reading <= pending_readings.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Long hold-off of the output, counted here on its own.
  always @(posedge clk) begin
    if (rst) begin
      hold_off <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      hold_off <= (hold_left != 1);
    end else if (hold_request && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_off <= 1'b1;
    end else begin
      hold_off <= 1'b0;
    end
  end

  // Receiver: after each transfer draw how many presented cycles to stall
  // the next total, so the stall is already up when it appears.
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    int unsigned w;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      w = idle_on ? $urandom_range(0, 10) : 0;
      stall_left <= w;
      out_stall <= (w != 0);
    end else if (out_valid && stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left != 1);
    end else begin
      out_stall <= (stall_left != 0);
    end
  end

  // Monitor: check output transfers first, then predict accepted readings.
  always @(posedge clk) begin
    logic [TICK_W-1:0] want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_millis.size() == 0) begin
          report_mismatch("total with none expected", millis, '0);
        end else begin
          want = expected_millis.pop_front();
          if (millis !== want)
            report_mismatch("millis", millis, want);
        end
      end
      if (in_valid && !in_stall)
        expected_millis.push_back(accumulate_millis(tick_reading));
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL tick_to_millisecond_accumulator_unit");
      $finish;
    end
  end

  initial begin
    logic [RATE_W-1:0] phase_rates[RANDOM_PHASES];
    logic [31:0] hz;
    phase_rates = '{23'd709379, 23'd0, 23'd1, 23'h7F_FFFF, 23'd4294967, 23'd1000,
                    23'd2, 23'd999, 23'd0, 23'd0, 23'd709379, 23'd0};
    phase_rates[8] = $urandom_range(1, 5000);
    phase_rates[9] = RATE_W'($urandom);
    phase_rates[11] = RATE_W'($urandom);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: priming, counter wrap, zero gap, gaps around one period
    queue_reading(32'hFFFF_FFF0);
    queue_reading(32'h0000_0010);
    queue_reading(32'h0000_0010);
    queue_reading(gen_last + 32'd709378);
    queue_reading(gen_last + 32'd709379);
    queue_reading(gen_last + 32'd709380);
    queue_reading(gen_last + 32'hFFFF_FFFF);
    queue_reading(32'hFFFF_FFFF);
    queue_reading(gen_last + 32'd1);
    queue_reading(gen_last + 32'd1);
    wait_for_drain();

    // Largest rate: leave a big remainder, then drop the rate under it
    write_rate(23'h7F_FFFF);
    queue_reading(gen_last + 32'd8388606);
    queue_reading(gen_last + 32'd8388606);
    wait_for_drain();
    write_rate(23'd1000);
    queue_reading(gen_last + 32'd5);
    wait_for_drain();

    // Zero selects the default rate
    write_rate(23'd0);
    queue_reading(gen_last + 32'd709379);
    queue_reading(gen_last + 32'd1);
    wait_for_drain();

    // Rate of one: every tick is a whole second
    write_rate(23'd1);
    queue_reading(gen_last + 32'hFFFF_FFFF);
    queue_reading(gen_last + 32'd7);
    wait_for_drain();

    write_rate(23'd4294967);
    queue_reading(gen_last + 32'd4294966);
    queue_reading(gen_last + 32'd4294967);
    wait_for_drain();

    // Random phases, one rate each; rate changes keep the old remainder
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_rate(phase_rates[p]);
      idle_on = !(p == 3 || p == 7);
      @(negedge clk);
      if (p == 5)
        hold_request = 1'b1;
      hz = (gen_rate != '0) ? 32'(gen_rate) : 32'(DEFAULT_RATE_HZ);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Mostly steady advances; now and then a jump to an arbitrary reading
        if ($urandom_range(0, 15) == 0)
          queue_reading($urandom);
        else
          queue_reading(gen_last + draw_delta(hz));
      end
      wait_for_drain();
    end

    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("PASS tick_to_millisecond_accumulator_unit");
    else
      $display("FAIL tick_to_millisecond_accumulator_unit");
    $finish;
  end

endmodule

### sim.f
design/tma_pkg.sv
design/tma_serdiv.sv
design/tick_to_millisecond_accumulator_unit.sv
sim/tick_to_millisecond_accumulator_unit_tb.sv
